@@ rtl/rcam_pkg.sv @@
package rcam_pkg;

   // Field and register widths.
   localparam int COEF_W  = 62;
   localparam int MOD_W   = 63;
   localparam int SLOT_W  = 8;
   localparam int PRIME_W = 9;
   localparam int FUNC_W  = 3;
   localparam int MULT_W  = 16;
   localparam int CSR_IDX_W = 1;

   // Block geometry. SIDE must be a power of two.
   localparam int SIDE      = 64;
   localparam int SIDE_W    = $clog2(SIDE);
   localparam int ROT_W     = SIDE_W + 2;
   localparam int PRIME_MAX = 257;

   // One reduction stage per quotient bit of a COEF_W-bit coefficient.
   localparam int RED_STAGES = COEF_W;

   localparam logic [MOD_W-1:0]   MOD_MAX   = MOD_W'(1) << COEF_W;
   localparam logic [PRIME_W-1:0] PRIME_LOW = PRIME_W'(3);
   localparam logic [PRIME_W-1:0] PRIME_TOP = PRIME_W'(PRIME_MAX);

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_TRANSPOSE = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_CONJUGATE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INVERSE   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_XY_AUTO   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_ROTATE    = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIME   = 1'b1;

   // Everything about a word that does not depend on the coefficient values.
   typedef struct packed {
      logic              bad;
      logic [SLOT_W-1:0] dslot;
      logic [SIDE_W-1:0] drow;
      logic [SIDE_W-1:0] dcol;
      logic              swap;
      logic              neg_re;
      logic              neg_im;
   } meta_type;

   // One restoring step of the remainder: subtract q shifted left by k if it fits.
   function automatic logic [COEF_W-1:0] red_step(input logic [COEF_W-1:0] rem,
                                                  input logic [MOD_W-1:0]  q,
                                                  input int                k);
      logic [MOD_W-1:0]  hi;
      logic [COEF_W-1:0] qs;
      hi = q >> (COEF_W - k);
      qs = COEF_W'(q << k);
      if (hi == '0 && rem >= qs) begin
         return rem - qs;
      end
      return rem;
   endfunction

endpackage

@@ rtl/rcam_mod_pipe.sv @@
module rcam_mod_pipe (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  rcam_pkg::meta_type       in_meta,
   input  logic [rcam_pkg::COEF_W-1:0] in_re,
   input  logic [rcam_pkg::COEF_W-1:0] in_im,
   input  logic [rcam_pkg::MOD_W-1:0]  modulus,
   output logic                     out_valid,
   output rcam_pkg::meta_type       out_meta,
   output logic [rcam_pkg::COEF_W-1:0] out_re,
   output logic [rcam_pkg::COEF_W-1:0] out_im
);
   import rcam_pkg::*;

   // Stage i subtracts modulus shifted by (COEF_W-1-i) from both parts.
   logic              valid_ff [RED_STAGES];
   meta_type          meta_ff  [RED_STAGES];
   logic [COEF_W-1:0] re_ff    [RED_STAGES];
   logic [COEF_W-1:0] im_ff    [RED_STAGES];

   logic              valid_prev [RED_STAGES];
   meta_type          meta_prev  [RED_STAGES];
   logic [COEF_W-1:0] re_prev    [RED_STAGES];
   logic [COEF_W-1:0] im_prev    [RED_STAGES];

   for (genvar i = 0; i < RED_STAGES; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign valid_prev[i] = in_valid;
         assign meta_prev[i]  = in_meta;
         assign re_prev[i]    = in_re;
         assign im_prev[i]    = in_im;
      end else begin : g_next
         assign valid_prev[i] = valid_ff[i-1];
         assign meta_prev[i]  = meta_ff[i-1];
         assign re_prev[i]    = re_ff[i-1];
         assign im_prev[i]    = im_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_prev[i];
         end
      end

      always_ff @(posedge clock) begin
         meta_ff[i] <= meta_prev[i];
         re_ff[i]   <= red_step(re_prev[i], modulus, COEF_W - 1 - i);
         im_ff[i]   <= red_step(im_prev[i], modulus, COEF_W - 1 - i);
      end
   end

   assign out_valid = valid_ff[RED_STAGES-1];
   assign out_meta  = meta_ff[RED_STAGES-1];
   assign out_re    = re_ff[RED_STAGES-1];
   assign out_im    = im_ff[RED_STAGES-1];

endmodule

@@ rtl/ring_coefficient_automorphism_map.sv @@
// Coefficient map for one Galois automorphism. Each word on the req_ ports is
// one source coefficient pair with its slot, row and column; the block answers
// with its destination coordinates and transformed pair on the rsp_ ports.
// A new word is taken in every cycle (busy stays low), and each answer appears
// with rsp_valid high for one cycle after the word has passed through the input
// register, then the stages that reduce both coefficients modulo the modulus
// one quotient bit per stage, and then the result register.
// The receiver cannot stall the block, so rsp_valid must be taken when it is
// shown. Write the modulus and prime registers only while no word is in flight.
module ring_coefficient_automorphism_map (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration.
   input  logic                           csr_write,
   input  logic [rcam_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rcam_pkg::MOD_W-1:0]     csr_data,
   // Request.
   input  logic                           start,
   output logic                           busy,
   input  logic [rcam_pkg::FUNC_W-1:0]    req_func,
   input  logic [rcam_pkg::SLOT_W-1:0]    req_slot,
   input  logic [rcam_pkg::SIDE_W-1:0]    req_row,
   input  logic [rcam_pkg::SIDE_W-1:0]    req_col,
   input  logic [rcam_pkg::COEF_W-1:0]    req_real_coeff,
   input  logic [rcam_pkg::COEF_W-1:0]    req_imag_coeff,
   input  logic [rcam_pkg::MULT_W-1:0]    req_mult_x,
   input  logic [rcam_pkg::MULT_W-1:0]    req_mult_y,
   input  logic [rcam_pkg::SLOT_W-1:0]    req_slot_shift,
   // Response.
   output logic                           rsp_valid,
   output logic [rcam_pkg::SLOT_W-1:0]    rsp_dest_slot,
   output logic [rcam_pkg::SIDE_W-1:0]    rsp_dest_row,
   output logic [rcam_pkg::SIDE_W-1:0]    rsp_dest_col,
   output logic [rcam_pkg::COEF_W-1:0]    rsp_real_out,
   output logic [rcam_pkg::COEF_W-1:0]    rsp_imag_out,
   output logic                           rsp_bad_operand
);
   import rcam_pkg::*;

   // Configuration registers.
   logic [MOD_W-1:0]   modulus_ff;
   logic [PRIME_W-1:0] prime_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_W'(2);
         prime_ff   <= PRIME_LOW;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_data;
            CSR_PRIME:   prime_ff   <= csr_data[PRIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Every cycle is open for a new word.
   assign busy = 1'b0;

   // Input register.
   logic               in_valid_ff;
   logic [FUNC_W-1:0]  func_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SIDE_W-1:0]  row_ff;
   logic [SIDE_W-1:0]  col_ff;
   logic [COEF_W-1:0]  re_ff;
   logic [COEF_W-1:0]  im_ff;
   logic [MULT_W-1:0]  mx_ff;
   logic [MULT_W-1:0]  my_ff;
   logic [SLOT_W-1:0]  shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         func_ff  <= req_func;
         slot_ff  <= req_slot;
         row_ff   <= req_row;
         col_ff   <= req_col;
         re_ff    <= req_real_coeff;
         im_ff    <= req_imag_coeff;
         mx_ff    <= req_mult_x;
         my_ff    <= req_mult_y;
         shift_ff <= req_slot_shift;
      end
   end

   // Decode of the word: validity checks, destination coordinates and the
   // sign and swap pattern that is applied once the coefficients are reduced.
   logic [PRIME_W-1:0] slots;
   logic [PRIME_W-1:0] inv_sum;
   logic [PRIME_W-1:0] inv_slot;
   logic [PRIME_W-1:0] rot_slot;
   logic [ROT_W-1:0]   row_prod;
   logic [ROT_W-1:0]   col_prod;
   logic [1:0]         quarter;
   logic               bad;
   meta_type           meta;

   always_comb begin
      slots    = prime_ff - PRIME_W'(1);
      inv_sum  = PRIME_W'(slot_ff) + (slots >> 1);
      inv_slot = (inv_sum >= slots) ? inv_sum - slots : inv_sum;
      rot_slot = (slot_ff >= shift_ff) ? PRIME_W'(slot_ff) - PRIME_W'(shift_ff)
                                       : PRIME_W'(slot_ff) + slots - PRIME_W'(shift_ff);
      // The products only matter modulo 4*SIDE.
      row_prod = ROT_W'(row_ff) * mx_ff[ROT_W-1:0];
      col_prod = ROT_W'(col_ff) * my_ff[ROT_W-1:0];
      quarter  = row_prod[ROT_W-1:SIDE_W] - col_prod[ROT_W-1:SIDE_W];

      bad = 1'b0;
      if (func_ff > FUNC_ROTATE) begin
         bad = 1'b1;
      end
      if (modulus_ff < MOD_W'(2) || modulus_ff > MOD_MAX) begin
         bad = 1'b1;
      end
      if (prime_ff < PRIME_LOW || prime_ff > PRIME_TOP) begin
         bad = 1'b1;
      end
      if (PRIME_W'(slot_ff) >= slots) begin
         bad = 1'b1;
      end
      if (func_ff == FUNC_ROTATE && PRIME_W'(shift_ff) >= slots) begin
         bad = 1'b1;
      end
      if (func_ff == FUNC_XY_AUTO && (!mx_ff[0] || !my_ff[0])) begin
         bad = 1'b1;
      end

      meta.bad    = bad;
      meta.dslot  = slot_ff;
      meta.drow   = row_ff;
      meta.dcol   = col_ff;
      meta.swap   = 1'b0;
      meta.neg_re = 1'b0;
      meta.neg_im = 1'b0;
      case (func_ff)
         FUNC_TRANSPOSE: begin
            meta.drow = col_ff;
            meta.dcol = row_ff;
         end
         FUNC_CONJUGATE: begin
            meta.neg_im = 1'b1;
         end
         FUNC_INVERSE: begin
            meta.dslot = inv_slot[SLOT_W-1:0];
         end
         FUNC_XY_AUTO: begin
            meta.drow = row_prod[SIDE_W-1:0];
            meta.dcol = col_prod[SIDE_W-1:0];
            // Multiply by the fourth root of unity raised to the quarter count.
            case (quarter)
               2'd1: begin
                  meta.swap   = 1'b1;
                  meta.neg_re = 1'b1;
               end
               2'd2: begin
                  meta.neg_re = 1'b1;
                  meta.neg_im = 1'b1;
               end
               2'd3: begin
                  meta.swap   = 1'b1;
                  meta.neg_im = 1'b1;
               end
               default: ;
            endcase
         end
         FUNC_ROTATE: begin
            meta.dslot = rot_slot[SLOT_W-1:0];
         end
         default: ;
      endcase
   end

   // Reduction of both coefficients modulo the modulus.
   logic              red_valid;
   meta_type          red_meta;
   logic [COEF_W-1:0] red_re;
   logic [COEF_W-1:0] red_im;

   rcam_mod_pipe u_mod_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_meta   (meta),
      .in_re     (re_ff),
      .in_im     (im_ff),
      .modulus   (modulus_ff),
      .out_valid (red_valid),
      .out_meta  (red_meta),
      .out_re    (red_re),
      .out_im    (red_im)
   );

   // Swap and negate, then zero everything for a rejected word.
   logic [COEF_W-1:0] src_re;
   logic [COEF_W-1:0] src_im;
   logic [COEF_W-1:0] fin_re;
   logic [COEF_W-1:0] fin_im;

   always_comb begin
      src_re = red_meta.swap ? red_im : red_re;
      src_im = red_meta.swap ? red_re : red_im;
      fin_re = src_re;
      fin_im = src_im;
      if (red_meta.neg_re && src_re != '0) begin
         fin_re = COEF_W'(modulus_ff - MOD_W'(src_re));
      end
      if (red_meta.neg_im && src_im != '0) begin
         fin_im = COEF_W'(modulus_ff - MOD_W'(src_im));
      end
   end

   // Result register.
   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [SIDE_W-1:0]  rsp_row_ff;
   logic [SIDE_W-1:0]  rsp_col_ff;
   logic [COEF_W-1:0]  rsp_re_ff;
   logic [COEF_W-1:0]  rsp_im_ff;
   logic               rsp_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= red_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bad_ff <= red_meta.bad;
      if (red_meta.bad) begin
         rsp_slot_ff <= '0;
         rsp_row_ff  <= '0;
         rsp_col_ff  <= '0;
         rsp_re_ff   <= '0;
         rsp_im_ff   <= '0;
      end else begin
         rsp_slot_ff <= red_meta.dslot;
         rsp_row_ff  <= red_meta.drow;
         rsp_col_ff  <= red_meta.dcol;
         rsp_re_ff   <= fin_re;
         rsp_im_ff   <= fin_im;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dest_slot   = rsp_slot_ff;
   assign rsp_dest_row    = rsp_row_ff;
   assign rsp_dest_col    = rsp_col_ff;
   assign rsp_real_out    = rsp_re_ff;
   assign rsp_imag_out    = rsp_im_ff;
   assign rsp_bad_operand = rsp_bad_ff;

endmodule
